// ----- design/shortest_remaining_time_scheduler_defines.svh -----
// Assertion helpers shared by the scheduler RTL.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define SRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define SRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/srts_pkg.sv -----
package srts_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int TIME_W   = 16;
  localparam int CLK_W    = 32;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_TAT,
    ST_WAIT,
    ST_OUT
  } state_e;

  // Write request into the job table
  typedef struct packed {
    logic              wr_all;
    logic              wr_rem;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } tbl_wr_t;

endpackage

// ----- design/srts_alu.sv -----
module srts_alu import srts_pkg::*; (
  input  logic [CLK_W-1:0] a_i,
  input  logic [CLK_W-1:0] b_i,
  output logic [CLK_W-1:0] diff_o,
  output logic             borrow_o
);

  // Shared subtractor: compares, decrements and time differences
  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

// ----- design/srts_job_table.sv -----
module srts_job_table import srts_pkg::*; (
  input  logic              clk_i,
  input  tbl_wr_t           wr_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  output logic [TIME_W-1:0] rd_arrival_o,
  output logic [TIME_W-1:0] rd_burst_o,
  output logic [TIME_W-1:0] rd_remaining_o
);

  logic [TIME_W-1:0] arrival_q   [MAX_JOBS];
  logic [TIME_W-1:0] burst_q     [MAX_JOBS];
  logic [TIME_W-1:0] remaining_q [MAX_JOBS];

  // Store a new job or update the served job's remaining time
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_all) begin
      arrival_q[wr_i.idx]   <= wr_i.arrival;
      burst_q[wr_i.idx]     <= wr_i.burst;
      remaining_q[wr_i.idx] <= wr_i.remaining;
    end else if (wr_i.wr_rem) begin
      remaining_q[wr_i.idx] <= wr_i.remaining;
    end
  end

  // Single read port, entry picked by the sequencer
  assign rd_arrival_o   = arrival_q[rd_idx_i];
  assign rd_burst_o     = burst_q[rd_idx_i];
  assign rd_remaining_o = remaining_q[rd_idx_i];

endmodule

// ----- design/shortest_remaining_time_scheduler.sv -----
// Load, clear and unused commands complete without leaving idle; no result is produced.
// A tick scans the loaded jobs one entry a cycle through the shared subtractor,
// updates the served job, forms turnaround and waiting time if it finishes, and
// accepts no new request until its result has been placed on the output.
// Reset empties the table and zeroes the clock and both job counts;
// table entries are undefined until loaded.
`include "shortest_remaining_time_scheduler_defines.svh"

module shortest_remaining_time_scheduler import srts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [TIME_W-1:0] arrival_time_i,
  input  logic [TIME_W-1:0] burst_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              idle_o,
  output logic [3:0]        job_index_o,
  output logic              finished_o,
  output logic [CLK_W-1:0]  completion_time_o,
  output logic [CLK_W-1:0]  turnaround_time_o,
  output logic [CLK_W-1:0]  waiting_time_o,
  output logic              all_done_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  loaded_q, loaded_d;
  logic [CNT_W-1:0]  fin_cnt_q, fin_cnt_d;
  logic [CLK_W-1:0]  clock_q, clock_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              have_q, have_d;
  logic [IDX_W-1:0]  best_q, best_d;
  logic [TIME_W-1:0] best_rem_q, best_rem_d;
  logic              res_fin_q, res_fin_d;
  logic [CLK_W-1:0]  tat_q, tat_d;
  logic [CLK_W-1:0]  wt_q, wt_d;
  logic              out_valid_q, out_valid_d;
  logic              idle_q, idle_d;
  logic [3:0]        job_index_q, job_index_d;
  logic              finished_q, finished_d;
  logic [CLK_W-1:0]  comp_out_q, comp_out_d;
  logic [CLK_W-1:0]  tat_out_q, tat_out_d;
  logic [CLK_W-1:0]  wt_out_q, wt_out_d;
  logic              all_done_q, all_done_d;

  tbl_wr_t           tbl_wr;
  logic [IDX_W-1:0]  rd_idx;
  logic [TIME_W-1:0] rd_arrival;
  logic [TIME_W-1:0] rd_burst;
  logic [TIME_W-1:0] rd_rem;
  logic [CLK_W-1:0]  alu_a;
  logic [CLK_W-1:0]  alu_b;
  logic [CLK_W-1:0]  alu_diff;
  logic              alu_borrow;
  logic              arrived;

  srts_job_table u_table (
    .clk_i          (clk_i),
    .wr_i           (tbl_wr),
    .rd_idx_i       (rd_idx),
    .rd_arrival_o   (rd_arrival),
    .rd_burst_o     (rd_burst),
    .rd_remaining_o (rd_rem)
  );

  srts_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  assign arrived = ({{(CLK_W-TIME_W){1'b0}}, rd_arrival} <= clock_q);

  // Sequence commands, scan and result formation
  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    fin_cnt_d   = fin_cnt_q;
    clock_d     = clock_q;
    scan_d      = scan_q;
    have_d      = have_q;
    best_d      = best_q;
    best_rem_d  = best_rem_q;
    res_fin_d   = res_fin_q;
    tat_d       = tat_q;
    wt_d        = wt_q;
    out_valid_d = out_valid_q;
    idle_d      = idle_q;
    job_index_d = job_index_q;
    finished_d  = finished_q;
    comp_out_d  = comp_out_q;
    tat_out_d   = tat_out_q;
    wt_out_d    = wt_out_q;
    all_done_d  = all_done_q;
    tbl_wr      = '0;
    rd_idx      = best_q;
    alu_a       = '0;
    alu_b       = '0;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_LOAD: begin
              if (loaded_q < CNT_W'(MAX_JOBS)) begin
                tbl_wr.wr_all    = 1'b1;
                tbl_wr.idx       = loaded_q[IDX_W-1:0];
                tbl_wr.arrival   = arrival_time_i;
                tbl_wr.burst     = burst_length_i;
                tbl_wr.remaining = burst_length_i;
                loaded_d         = loaded_q + CNT_W'(1);
                if (burst_length_i == '0) begin
                  fin_cnt_d = fin_cnt_q + CNT_W'(1);
                end
              end
            end
            CMD_TICK: begin
              state_d    = ST_SCAN;
              scan_d     = '0;
              have_d     = 1'b0;
              best_d     = '0;
              best_rem_d = '0;
              res_fin_d  = 1'b0;
            end
            CMD_CLEAR: begin
              loaded_d  = '0;
              fin_cnt_d = '0;
              clock_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // One entry a cycle: keep the smallest arrived nonzero remaining time
        rd_idx = scan_q[IDX_W-1:0];
        alu_a  = {{(CLK_W-TIME_W){1'b0}}, rd_rem};
        alu_b  = {{(CLK_W-TIME_W){1'b0}}, best_rem_q};
        if (scan_q == loaded_q) begin
          state_d = ST_UPD;
        end else begin
          if (arrived && (rd_rem != '0) && (!have_q || alu_borrow)) begin
            have_d     = 1'b1;
            best_d     = scan_q[IDX_W-1:0];
            best_rem_d = rd_rem;
          end
          scan_d = scan_q + CNT_W'(1);
        end
      end
      ST_UPD: begin
        // Advance the clock and decrement the served job
        alu_a = {{(CLK_W-TIME_W){1'b0}}, best_rem_q};
        alu_b = CLK_W'(1);
        if (clock_q != '1) begin
          clock_d = clock_q + CLK_W'(1);
        end
        state_d = ST_OUT;
        if (have_q) begin
          tbl_wr.wr_rem    = 1'b1;
          tbl_wr.idx       = best_q;
          tbl_wr.remaining = alu_diff[TIME_W-1:0];
          if (alu_diff[TIME_W-1:0] == '0) begin
            res_fin_d = 1'b1;
            fin_cnt_d = fin_cnt_q + CNT_W'(1);
            state_d   = ST_TAT;
          end
        end
      end
      ST_TAT: begin
        alu_a   = clock_q;
        alu_b   = {{(CLK_W-TIME_W){1'b0}}, rd_arrival};
        tat_d   = alu_diff;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        // Waiting time floors at zero after clock saturation
        alu_a   = tat_q;
        alu_b   = {{(CLK_W-TIME_W){1'b0}}, rd_burst};
        wt_d    = alu_borrow ? '0 : alu_diff;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          idle_d      = !have_q;
          job_index_d = have_q ? 4'(best_q) : '0;
          finished_d  = res_fin_q;
          comp_out_d  = res_fin_q ? clock_q : '0;
          tat_out_d   = res_fin_q ? tat_q : '0;
          wt_out_d    = res_fin_q ? wt_q : '0;
          all_done_d  = (fin_cnt_q == loaded_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loaded_q    <= '0;
      fin_cnt_q   <= '0;
      clock_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      fin_cnt_q   <= fin_cnt_d;
      clock_q     <= clock_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold working and result payload
  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    have_q      <= have_d;
    best_q      <= best_d;
    best_rem_q  <= best_rem_d;
    res_fin_q   <= res_fin_d;
    tat_q       <= tat_d;
    wt_q        <= wt_d;
    idle_q      <= idle_d;
    job_index_q <= job_index_d;
    finished_q  <= finished_d;
    comp_out_q  <= comp_out_d;
    tat_out_q   <= tat_out_d;
    wt_out_q    <= wt_out_d;
    all_done_q  <= all_done_d;
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign idle_o            = idle_q;
  assign job_index_o       = job_index_q;
  assign finished_o        = finished_q;
  assign completion_time_o = comp_out_q;
  assign turnaround_time_o = tat_out_q;
  assign waiting_time_o    = wt_out_q;
  assign all_done_o        = all_done_q;

  `SRTS_ASSERT(a_fin_le_loaded, fin_cnt_q <= loaded_q, "finished count exceeds loaded count")
  `SRTS_ASSERT(a_loaded_bound, loaded_q <= CNT_W'(MAX_JOBS), "loaded count exceeds table size")
  `SRTS_ASSERT_NEXT(a_clock_mono, state_q != ST_IDLE, clock_q >= $past(clock_q), "clock moved back during a tick")
  `SRTS_ASSERT(a_tat_has_job, (state_q == ST_TAT) -> (have_q && res_fin_q), "finish path without a served job")

endmodule

// ----- tb/tb_shortest_remaining_time_scheduler.sv -----
`timescale 1ns / 1ps

module tb_shortest_remaining_time_scheduler import srts_pkg::*;;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned TARGET_ITEMS = 500;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned TICK_CAP = 80;

  // One tick report as it leaves the block
  typedef struct packed {
    logic             idle;
    logic [3:0]       job_index;
    logic             finished;
    logic [CLK_W-1:0] completion;
    logic [CLK_W-1:0] turnaround;
    logic [CLK_W-1:0] waiting;
    logic             all_done;
  } tick_report_t;

  // Job table mirror; predicts one tick report per accepted tick
  class sched_scoreboard;
    logic [TIME_W-1:0] arrival_of[MAX_JOBS];
    logic [TIME_W-1:0] burst_of[MAX_JOBS];
    logic [TIME_W-1:0] left_of[MAX_JOBS];
    int unsigned       jobs_loaded;
    int unsigned       jobs_finished;
    logic [CLK_W-1:0]  sched_clock;
    tick_report_t      tick_reports_q[$];
    int unsigned       errors;
    int unsigned       n_loads, n_ticks, n_idle, n_done, n_clears, n_ignored;

    function new();
      clear_table();
    endfunction

    function void clear_table();
      foreach (left_of[i]) begin
        arrival_of[i] = '0;
        burst_of[i]   = '0;
        left_of[i]    = '0;
      end
      jobs_loaded   = 0;
      jobs_finished = 0;
      sched_clock   = '0;
    endfunction

    function void apply_request(logic [1:0] cmd, logic [TIME_W-1:0] arr,
                                logic [TIME_W-1:0] bur);
      tick_report_t      rep;
      bit                found;
      logic [IDX_W-1:0]  pick;
      logic [TIME_W-1:0] pick_left;
      rep       = '0;
      found     = 1'b0;
      pick      = '0;
      pick_left = '0;
      if (cmd == CMD_LOAD) begin
        // append the job; a zero burst counts as finished right away
        if (jobs_loaded < MAX_JOBS) begin
          arrival_of[IDX_W'(jobs_loaded)] = arr;
          burst_of[IDX_W'(jobs_loaded)]   = bur;
          left_of[IDX_W'(jobs_loaded)]    = bur;
          if (bur == '0) jobs_finished++;
          jobs_loaded++;
          n_loads++;
        end else begin
          n_ignored++;
        end
      end else if (cmd == CMD_CLEAR) begin
        clear_table();
        n_clears++;
      end else if (cmd == CMD_TICK) begin
        // pick the arrived job with the least work left, lowest index on a tie
        for (int i = 0; i < jobs_loaded; i++) begin
          if (CLK_W'(arrival_of[IDX_W'(i)]) <= sched_clock && left_of[IDX_W'(i)] != '0 &&
              (!found || left_of[IDX_W'(i)] < pick_left)) begin
            found     = 1'b1;
            pick      = IDX_W'(i);
            pick_left = left_of[IDX_W'(i)];
          end
        end
        // advance the clock, saturating at the top
        if (sched_clock != '1) sched_clock++;
        if (!found) begin
          rep.idle = 1'b1;
          n_idle++;
        end else begin
          left_of[pick]--;
          rep.job_index = 4'(pick);
          if (left_of[pick] == '0) begin
            jobs_finished++;
            rep.finished   = 1'b1;
            rep.completion = sched_clock;
            rep.turnaround = sched_clock - CLK_W'(arrival_of[pick]);
            rep.waiting    = (rep.turnaround >= CLK_W'(burst_of[pick])) ?
                             rep.turnaround - CLK_W'(burst_of[pick]) : '0;
            n_done++;
          end
        end
        rep.all_done = (jobs_finished == jobs_loaded);
        tick_reports_q.push_back(rep);
        n_ticks++;
      end else begin
        n_ignored++;
      end
    endfunction

    function void check_field(string name, logic [CLK_W-1:0] want, logic [CLK_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_tick_report(tick_report_t got);
      tick_report_t want;
      if (tick_reports_q.size() == 0) begin
        $display("%0t: tick report with no tick pending: expected none, actual %p",
                 $time, got);
        errors++;
        return;
      end
      want = tick_reports_q.pop_front();
      check_field("idle", CLK_W'(want.idle), CLK_W'(got.idle));
      check_field("job_index", CLK_W'(want.job_index), CLK_W'(got.job_index));
      check_field("finished", CLK_W'(want.finished), CLK_W'(got.finished));
      check_field("completion_time", want.completion, got.completion);
      check_field("turnaround_time", want.turnaround, got.turnaround);
      check_field("waiting_time", want.waiting, got.waiting);
      check_field("all_done", CLK_W'(want.all_done), CLK_W'(got.all_done));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        command_i = '0;
  logic [TIME_W-1:0] arrival_time_i = '0;
  logic [TIME_W-1:0] burst_length_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              idle_o;
  logic [3:0]        job_index_o;
  logic              finished_o;
  logic [CLK_W-1:0]  completion_time_o;
  logic [CLK_W-1:0]  turnaround_time_o;
  logic [CLK_W-1:0]  waiting_time_o;
  logic              all_done_o;

  sched_scoreboard sb;
  int unsigned     sender_idle_pct = 0;
  int unsigned     receiver_stall_pct = 0;
  int unsigned     hold_request = 0;
  int unsigned     hold_left = 0;
  int unsigned     items_sent = 0;
  int unsigned     cycle_count = 0;

  shortest_remaining_time_scheduler i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .idle_o            (idle_o),
    .job_index_o       (job_index_o),
    .finished_o        (finished_o),
    .completion_time_o (completion_time_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .all_done_o        (all_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d tick reports outstanding", $time,
               cycle_count, sb.tick_reports_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check accepted tick reports, then stall at random or hold off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_tick_report({idle_o, job_index_o, finished_o, completion_time_o,
                              turnaround_time_o, waiting_time_o, all_done_o});
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] cmd, input logic [TIME_W-1:0] arr,
                              input logic [TIME_W-1:0] bur);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    arrival_time_i <= arr;
    burst_length_i <= bur;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CMD_TICK || cmd == CMD_CLEAR || (cmd == CMD_LOAD && sb.jobs_loaded < MAX_JOBS))
      items_sent++;
    sb.apply_request(cmd, arr, bur);
  endtask

  // Load a job: mostly short and early, sometimes full range or zero burst
  task automatic send_random_load(input int unsigned max_arr);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)
      send_request(CMD_LOAD, TIME_W'($urandom), TIME_W'($urandom));
    else if (r < 8)
      send_request(CMD_LOAD, TIME_W'($urandom_range(max_arr)), '0);
    else
      send_request(CMD_LOAD, TIME_W'($urandom_range(max_arr)), TIME_W'($urandom_range(6, 1)));
  endtask

  initial begin
    int unsigned n_jobs;
    int unsigned ticks;
    int unsigned phase;
    int unsigned r;
    bit          hold_done;
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    idle_by_phase  = '{0, 85, 0, 10};
    stall_by_phase = '{0, 0, 85, 10};
    hold_done = 1'b0;
    sb = new();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty table
    send_request(CMD_TICK, '0, '0);
    // preemption by a shorter late job, a zero burst, a job that never arrives
    send_request(CMD_LOAD, 16'd0, 16'd3);
    send_request(CMD_LOAD, 16'd1, 16'd1);
    send_request(CMD_LOAD, 16'd2, 16'd0);
    send_request(CMD_LOAD, 16'hFFFF, 16'hFFFF);
    repeat (5) send_request(CMD_TICK, '0, '0);
    // spare command code, then clear
    send_request(CMD_SPARE, TIME_W'($urandom), TIME_W'($urandom));
    send_request(CMD_CLEAR, TIME_W'($urandom), TIME_W'($urandom));
    // equal remaining times: lowest index first
    send_request(CMD_LOAD, 16'd0, 16'd2);
    send_request(CMD_LOAD, 16'd0, 16'd2);
    repeat (5) send_request(CMD_TICK, '0, '0);
    send_request(CMD_CLEAR, '0, '0);
    send_request(CMD_TICK, '0, '0);

    // random job sets run to completion, with some noise in between
    while (items_sent < TARGET_ITEMS) begin
      phase = (items_sent * 4) / TARGET_ITEMS;
      if (phase > 3) phase = 3;
      sender_idle_pct    = idle_by_phase[2'(phase)];
      receiver_stall_pct = stall_by_phase[2'(phase)];
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(8, 3))
          send_request(2'($urandom_range(3)), TIME_W'($urandom), TIME_W'($urandom));
      end else begin
        send_request(CMD_CLEAR, TIME_W'($urandom), TIME_W'($urandom));
        r = $urandom_range(99);
        if (r < 70)      n_jobs = $urandom_range(6, 1);
        else if (r < 90) n_jobs = $urandom_range(16, 7);
        else             n_jobs = $urandom_range(18, 17);
        repeat (n_jobs) send_random_load(n_jobs * 3);
        // stall the output for a long stretch while ticks keep coming
        if (!hold_done && items_sent >= 80) begin
          hold_request = LONG_HOLD_CYCLES;
          hold_done    = 1'b1;
        end
        ticks = 0;
        while (sb.jobs_finished != sb.jobs_loaded && ticks < TICK_CAP) begin
          if (sb.jobs_loaded < MAX_JOBS && $urandom_range(99) < 8)
            send_random_load(sb.sched_clock[TIME_W-1:0] + 3);
          else if ($urandom_range(99) < 2)
            send_request(CMD_SPARE, TIME_W'($urandom), TIME_W'($urandom));
          send_request(CMD_TICK, TIME_W'($urandom), TIME_W'($urandom));
          ticks++;
        end
        repeat ($urandom_range(2))
          send_request(CMD_TICK, TIME_W'($urandom), TIME_W'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding reports, then watch for strays
    while (sb.tick_reports_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Covered %0d loads (%0d requests ignored), %0d clears, %0d ticks", sb.n_loads,
             sb.n_ignored, sb.n_clears, sb.n_ticks);
    $display("of which %0d idle and %0d completing a job; %0d mismatches", sb.n_idle,
             sb.n_done, sb.errors);
    if (sb.errors == 0 && sb.tick_reports_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
